// ===== rtl/core/tsm_pkg.sv =====
// Shared constants, types and float compare for the two-way sorted merge unit.
`default_nettype none
package tsm_pkg;
    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_OUT
    } tsm_state_t;

    // Queue control from sequencer to the queue memories.
    typedef struct packed {
        logic             wr_en_first;
        logic             wr_en_second;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx_first;
        logic [IDX_W-1:0] rd_idx_second;
    } tsm_mem_ctl_t;

    // IEEE-754 single a < b, false whenever either operand is NaN.
    function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic res;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_zero && b_zero)) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = a[31];
        end else if (a[31]) begin
            res = (a[30:0] > b[30:0]);
        end else begin
            res = (a[30:0] < b[30:0]);
        end
        return res;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/tsm_queue_mem.sv =====
// Two queue memories, one per list, with registered read data.
`default_nettype none
module tsm_queue_mem (
    input  wire logic                 aclk,
    input  wire tsm_pkg::tsm_mem_ctl_t ctl,
    input  wire logic [31:0]          wr_data,
    output logic [31:0]               rd_first,
    output logic [31:0]               rd_second
);
    import tsm_pkg::*;

    logic [31:0] mem_first [QUEUE_DEPTH];
    logic [31:0] mem_second [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en_first) begin
            mem_first[ctl.wr_idx] <= wr_data;
        end
        if (ctl.wr_en_second) begin
            mem_second[ctl.wr_idx] <= wr_data;
        end
        rd_first <= mem_first[ctl.rd_idx_first];
        rd_second <= mem_second[ctl.rd_idx_second];
    end
endmodule
`default_nettype wire

// ===== rtl/core/tsm_merge_ctrl.sv =====
// Merge sequencer: pointers, end marks, head compare and result register.
`default_nettype none
module tsm_merge_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [31:0]           s_value,
    input  wire logic                  s_from_second,
    input  wire logic                  s_list_end,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [31:0]                m_merged_value,
    output logic                       m_came_from_second,
    output logic                       m_run_last,
    output logic                       m_overflow,
    output tsm_pkg::tsm_mem_ctl_t      mem_ctl,
    input  wire logic [31:0]           rd_first,
    input  wire logic [31:0]           rd_second
);
    import tsm_pkg::*;

    tsm_state_t state_reg, state_next;
    logic [IDX_W-1:0] head_first_reg, head_first_next;
    logic [IDX_W-1:0] head_second_reg, head_second_next;
    logic [FILL_W-1:0] fill_first_reg, fill_first_next;
    logic [FILL_W-1:0] fill_second_reg, fill_second_next;
    logic ended_first_reg, ended_first_next;
    logic ended_second_reg, ended_second_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg, out_value_next;
    logic out_src_reg, out_src_next;
    logic out_last_reg, out_last_next;
    logic out_ovf_reg, out_ovf_next;
    logic ovf_src_reg;

    logic accept;
    logic full_sel;
    logic [FILL_W-1:0] fill_sel;
    logic [IDX_W-1:0] head_sel;
    logic [FILL_W:0] wr_sum;
    logic can_pop;
    logic pick_first;
    logic [IDX_W-1:0] head_inc_first;
    logic [IDX_W-1:0] head_inc_second;

    assign accept = s_valid && s_ready;
    assign fill_sel = s_from_second ? fill_second_reg : fill_first_reg;
    assign head_sel = s_from_second ? head_second_reg : head_first_reg;
    assign full_sel = (fill_sel >= FILL_W'(QUEUE_DEPTH));
    assign wr_sum = {1'b0, FILL_W'(head_sel)} + {1'b0, fill_sel};
    assign can_pop = ((fill_first_reg != '0) && (fill_second_reg != '0))
                  || ((fill_first_reg != '0) && ended_second_reg)
                  || ((fill_second_reg != '0) && ended_first_reg);
    assign head_inc_first = (head_first_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                          : head_first_reg + 1'b1;
    assign head_inc_second = (head_second_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                           : head_second_reg + 1'b1;

    always_comb begin
        pick_first = 1'b0;
        if ((fill_first_reg != '0) && (fill_second_reg != '0)) begin
            pick_first = fp_less(rd_first, rd_second);
        end else if (fill_first_reg != '0) begin
            pick_first = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        head_first_next = head_first_reg;
        head_second_next = head_second_reg;
        fill_first_next = fill_first_reg;
        fill_second_next = fill_second_reg;
        ended_first_next = ended_first_reg;
        ended_second_next = ended_second_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_src_next = out_src_reg;
        out_last_next = out_last_reg;
        out_ovf_next = out_ovf_reg;
        s_ready = 1'b0;
        mem_ctl.wr_en_first = 1'b0;
        mem_ctl.wr_en_second = 1'b0;
        mem_ctl.wr_idx = (wr_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
                       ? IDX_W'(wr_sum - (FILL_W + 1)'(QUEUE_DEPTH)) : IDX_W'(wr_sum);
        mem_ctl.rd_idx_first = head_first_reg;
        mem_ctl.rd_idx_second = head_second_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_from_second) begin
                        ended_second_next = ended_second_reg | s_list_end;
                    end else begin
                        ended_first_next = ended_first_reg | s_list_end;
                    end
                    if (full_sel) begin
                        state_next = ST_OUT;
                    end else begin
                        mem_ctl.wr_en_first = !s_from_second;
                        mem_ctl.wr_en_second = s_from_second;
                        if (s_from_second) begin
                            fill_second_next = fill_second_reg + 1'b1;
                        end else begin
                            fill_first_next = fill_first_reg + 1'b1;
                        end
                        state_next = ST_READ;
                    end
                end
            end
            ST_OUT: begin
                // hold the overflow item until the output register is free
                if (!out_valid_next) begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_src_next = ovf_src_reg;
                    out_last_next = 1'b0;
                    out_ovf_next = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // heads are read here; data shows next cycle
                state_next = can_pop ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!out_valid_next) begin
                    out_valid_next = 1'b1;
                    out_ovf_next = 1'b0;
                    out_src_next = !pick_first;
                    out_value_next = pick_first ? rd_first : rd_second;
                    if (pick_first) begin
                        fill_first_next = fill_first_reg - 1'b1;
                        head_first_next = head_inc_first;
                    end else begin
                        fill_second_next = fill_second_reg - 1'b1;
                        head_second_next = head_inc_second;
                    end
                    out_last_next = ended_first_reg && ended_second_reg
                                 && (fill_first_next == '0) && (fill_second_next == '0);
                    if (out_last_next) begin
                        head_first_next = '0;
                        head_second_next = '0;
                        ended_first_next = 1'b0;
                        ended_second_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // keep the list of the accepted item for a later overflow result
    always_ff @(posedge aclk) begin
        if (accept) begin
            ovf_src_reg <= s_from_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_first_reg <= '0;
            head_second_reg <= '0;
            fill_first_reg <= '0;
            fill_second_reg <= '0;
            ended_first_reg <= 1'b0;
            ended_second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_first_reg <= head_first_next;
            head_second_reg <= head_second_next;
            fill_first_reg <= fill_first_next;
            fill_second_reg <= fill_second_next;
            ended_first_reg <= ended_first_next;
            ended_second_reg <= ended_second_next;
            out_valid_reg <= out_valid_next;
        end
        out_value_reg <= out_value_next;
        out_src_reg <= out_src_next;
        out_last_reg <= out_last_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_valid = out_valid_reg;
    assign m_merged_value = out_value_reg;
    assign m_came_from_second = out_src_reg;
    assign m_run_last = out_last_reg;
    assign m_overflow = out_ovf_reg;
endmodule
`default_nettype wire

// ===== rtl/core/two_way_sorted_merge_unit.sv =====
// Top level of the two-way sorted merge unit.
//
//  channel   ports                                          direction
//  s_        s_valid s_ready s_value s_from_second s_list_end  in
//  m_        m_valid m_ready m_merged_value m_came_from_second
//            m_run_last m_overflow                           out
//
// An item enters its queue unless full; each emitted result then takes
// one queue memory read and one float compare into the output register.
// An item that emits nothing returns to intake after the read.
// Reset is synchronous; queue contents need no clearing.
// A stalled output holds the sequencer in its emit or overflow step.
`default_nettype none
module two_way_sorted_merge_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_value,
    input  wire logic        s_from_second,
    input  wire logic        s_list_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_merged_value,
    output logic             m_came_from_second,
    output logic             m_run_last,
    output logic             m_overflow
);
    import tsm_pkg::*;

    tsm_mem_ctl_t mem_ctl;
    logic [31:0] rd_first;
    logic [31:0] rd_second;

    tsm_queue_mem u_mem (
        .aclk      (aclk),
        .ctl       (mem_ctl),
        .wr_data   (s_value),
        .rd_first  (rd_first),
        .rd_second (rd_second)
    );

    tsm_merge_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_value            (s_value),
        .s_from_second      (s_from_second),
        .s_list_end         (s_list_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_merged_value     (m_merged_value),
        .m_came_from_second (m_came_from_second),
        .m_run_last         (m_run_last),
        .m_overflow         (m_overflow),
        .mem_ctl            (mem_ctl),
        .rd_first           (rd_first),
        .rd_second          (rd_second)
    );

`ifndef SYNTHESIS
    a_no_double_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.wr_en_first && mem_ctl.wr_en_second))
        else $error("both queues written in one cycle");
    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> (m_merged_value == 32'd0) && !m_run_last)
        else $error("overflow item carries data");
    a_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.wr_en_first || mem_ctl.wr_en_second) |-> s_valid && s_ready)
        else $error("queue write without accepted item");
`endif
endmodule
`default_nettype wire
